// ----- sv/apsel_pkg.sv -----
// Package for the adaptive pursuit selector: arm count, fixed-point constants, item types.
`default_nettype none
package apsel_pkg;

  localparam int NUM_ARMS = 8;
  localparam int ARM_W    = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;

  localparam int Q_W      = 16;
  localparam int PMIN_W   = 13;
  localparam int FIELD_W  = 3;

  localparam int Q_ONE_INT  = 65536;
  localparam int SHARE_INT  = Q_ONE_INT / NUM_ARMS;
  localparam logic [Q_W-1:0] PROB_RESET =
    Q_W'((SHARE_INT > Q_ONE_INT - 1) ? (Q_ONE_INT - 1) : SHARE_INT);
  localparam logic [PMIN_W-1:0] PMIN_RESET  = PMIN_W'(655);
  localparam logic [Q_W-1:0]    ALPHA_RESET = Q_W'(52429);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  localparam logic REG_MIN_PROB   = 1'b0;
  localparam logic REG_LEARN_RATE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] arm;
    logic [Q_W-1:0]     reward;
    logic [Q_W-1:0]     random_draw;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] chosen_arm;
    logic [FIELD_W-1:0] best_arm;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/adaptive_pursuit_selector_core.sv -----
// Adaptive pursuit selector: reward table, probability update and roulette draw.
//
// Requests arrive on req/req_valid/req_stall and are taken at an edge with
// req_valid high and req_stall low. A write request (cmd 0) stores one reward
// estimate in the accept cycle and returns nothing; the block is ready again
// on the next cycle. A select request (cmd 1) runs a small sequencer around
// one shared 16x16 multiplier: an argmax scan over the arms, a probability
// pull on each arm (multiply, then add and write back), a roulette scan that
// stops at the first arm whose running sum passes the draw, and a final
// state that loads the result. The block is back in idle at the edge that
// raises res_valid.
// req_stall is high for the whole select.
// The result is held in an output register (res_valid/res); a stalled result
// stays put and the block still takes new requests meanwhile. A second select
// finishing while the first result is stalled waits in its final state.
// Reset (rst, synchronous) clears rewards to zero, sets every probability to
// one over NUM_ARMS and loads the register defaults; no clearing pass.
// Configuration is an APB port with read-back: min_probability at 0x0, learning_rate at 0x4.
`default_nettype none
module adaptive_pursuit_selector_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire apsel_pkg::req_t    req,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output apsel_pkg::res_t         res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int ARM_W  = apsel_pkg::ARM_W;
  localparam int Q_W    = apsel_pkg::Q_W;
  localparam int PMIN_W = apsel_pkg::PMIN_W;
  localparam int PM_W   = PMIN_W + ARM_W;
  localparam int SUM_W  = Q_W + 2;
  localparam logic [ARM_W-1:0] LAST_ARM = ARM_W'(apsel_pkg::NUM_ARMS - 1);
  localparam logic [SUM_W-1:0] Q_ONE    = SUM_W'(apsel_pkg::Q_ONE_INT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BEST = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DRAW = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state;
  logic [ARM_W-1:0]    idx;
  logic                ph;
  logic [ARM_W-1:0]    best;
  logic [Q_W-1:0]      best_val;
  logic [ARM_W-1:0]    chosen;
  logic [Q_W-1:0]      draw;
  logic [SUM_W-1:0]    sum;
  logic                dir;
  logic [2*Q_W-1:0]    prod;
  logic [PMIN_W-1:0]   min_probability;
  logic [Q_W-1:0]      learning_rate;
  logic [Q_W-1:0]      reward_estimate [apsel_pkg::NUM_ARMS];
  logic [Q_W-1:0]      arm_probability [apsel_pkg::NUM_ARMS];

  logic                cfg_wr;
  logic                req_acc;
  logic [PM_W-1:0]     pm_prod;
  logic [Q_W-1:0]      pmax;
  logic [Q_W-1:0]      p_cur;
  logic [Q_W-1:0]      target;
  logic [Q_W-1:0]      mag;
  logic [Q_W-1:0]      step;
  logic [Q_W-1:0]      p_next;
  logic [SUM_W-1:0]    sum_raw;
  logic [SUM_W-1:0]    sum_next;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (paddr[2] == apsel_pkg::REG_LEARN_RATE) ? 32'(learning_rate)
                                                           : 32'(min_probability);
  assign req_stall = (state != S_IDLE);
  assign req_acc   = req_valid && !req_stall;

  // pmax = 1 - (N-1)*pmin, clamped to [0, 0xFFFF]
  assign pm_prod = PM_W'(apsel_pkg::NUM_ARMS - 1) * PM_W'(min_probability);
  always_comb begin
    if (32'(pm_prod) >= apsel_pkg::Q_ONE_INT) begin
      pmax = '0;
    end else if (pm_prod == '0) begin
      pmax = '1;
    end else begin
      pmax = Q_W'(32'(apsel_pkg::Q_ONE_INT) - 32'(pm_prod));
    end
  end

  assign p_cur  = arm_probability[idx];
  assign target = (idx == best) ? pmax : Q_W'(min_probability);
  assign mag    = (target >= p_cur) ? (target - p_cur) : (p_cur - target);
  assign step   = prod[2*Q_W-1:Q_W];
  assign p_next = dir ? (p_cur + step) : (p_cur - step);

  assign sum_raw  = sum + SUM_W'(p_cur);
  assign sum_next = (sum_raw > Q_ONE) ? Q_ONE : sum_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      res_valid       <= 1'b0;
      min_probability <= apsel_pkg::PMIN_RESET;
      learning_rate   <= apsel_pkg::ALPHA_RESET;
      idx             <= '0;
      ph              <= 1'b0;
      for (int i = 0; i < apsel_pkg::NUM_ARMS; i++) begin
        reward_estimate[i] <= '0;
        arm_probability[i] <= apsel_pkg::PROB_RESET;
      end
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == apsel_pkg::REG_MIN_PROB) begin
          min_probability <= pwdata[PMIN_W-1:0];
        end else begin
          learning_rate <= pwdata[Q_W-1:0];
        end
      end

      if (state == S_DONE && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_acc) begin
            if (req.cmd == apsel_pkg::CMD_WRITE) begin
              if (32'(req.arm) < apsel_pkg::NUM_ARMS) begin
                reward_estimate[ARM_W'(req.arm)] <= req.reward;
              end
            end else begin
              draw     <= req.random_draw;
              best     <= '0;
              best_val <= reward_estimate[0];
              idx      <= ARM_W'(1);
              state    <= S_BEST;
            end
          end
        end
        S_BEST: begin
          // >= so the last index wins a tie
          if (reward_estimate[idx] >= best_val) begin
            best     <= idx;
            best_val <= reward_estimate[idx];
          end
          if (idx == LAST_ARM) begin
            idx   <= '0;
            ph    <= 1'b0;
            state <= S_UPD;
          end else begin
            idx <= idx + ARM_W'(1);
          end
        end
        S_UPD: begin
          if (!ph) begin
            dir  <= (target >= p_cur);
            prod <= (2*Q_W)'(learning_rate) * (2*Q_W)'(mag);
            ph   <= 1'b1;
          end else begin
            arm_probability[idx] <= p_next;
            ph <= 1'b0;
            if (idx == LAST_ARM) begin
              idx   <= '0;
              sum   <= '0;
              state <= S_DRAW;
            end else begin
              idx <= idx + ARM_W'(1);
            end
          end
        end
        S_DRAW: begin
          sum <= sum_next;
          if (sum_next > SUM_W'(draw)) begin
            chosen <= idx;
            state  <= S_DONE;
          end else if (idx == LAST_ARM) begin
            chosen <= '0;
            state  <= S_DONE;
          end else begin
            idx <= idx + ARM_W'(1);
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res.chosen_arm <= apsel_pkg::FIELD_W'(chosen);
            res.best_arm   <= apsel_pkg::FIELD_W'(best);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a write request never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req.cmd == apsel_pkg::CMD_WRITE && !res_valid) |=> !res_valid)
    else $error("result after write request");

  // a new result only comes out of the final state
  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside final state");

  // tracked best value matches the table entry during the later passes
  a_best_track: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD || state == S_DRAW) |-> reward_estimate[best] == best_val)
    else $error("best value out of step with reward table");

  // running sum never passes one
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAW) |-> sum <= Q_ONE)
    else $error("roulette sum above one");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the adaptive pursuit selector core: scoreboard, drivers, monitors.
`timescale 1ns / 100ps

class apsel_scoreboard;
  localparam int Q_W       = apsel_pkg::Q_W;
  localparam int PMIN_W    = apsel_pkg::PMIN_W;
  localparam int NUM_ARMS  = apsel_pkg::NUM_ARMS;
  localparam int FIELD_W   = apsel_pkg::FIELD_W;
  localparam int Q_ONE_INT = apsel_pkg::Q_ONE_INT;

  logic [Q_W-1:0]    reward_est [NUM_ARMS];
  logic [Q_W-1:0]    arm_prob [NUM_ARMS];
  logic [PMIN_W-1:0] pmin;
  logic [Q_W-1:0]    alpha;
  apsel_pkg::res_t   pending [$];
  int                errors;
  int                requests;
  int                selects;

  function new();
    pmin     = apsel_pkg::PMIN_RESET;
    alpha    = apsel_pkg::ALPHA_RESET;
    errors   = 0;
    requests = 0;
    selects  = 0;
    foreach (reward_est[i]) begin
      reward_est[i] = '0;
      arm_prob[i]   = apsel_pkg::PROB_RESET;
    end
  endfunction

  // Advance the pursuit state for one accepted request and queue the selection it yields.
  function void note_request(apsel_pkg::req_t r);
    int              best;
    int              chosen;
    longint          pmax_l;
    longint          target;
    longint          p;
    longint          step;
    longint          nxt;
    longint          acc;
    apsel_pkg::res_t want;
    requests++;
    if (r.cmd == apsel_pkg::CMD_WRITE) begin
      if (int'(r.arm) < NUM_ARMS) reward_est[r.arm] = r.reward;
      return;
    end
    best = 0;
    for (int i = 1; i < NUM_ARMS; i++) begin
      if (reward_est[i] >= reward_est[best]) best = i;
    end
    pmax_l = longint'(Q_ONE_INT) - longint'(NUM_ARMS - 1) * longint'(pmin);
    if (pmax_l < 0) pmax_l = 0;
    if (pmax_l > Q_ONE_INT - 1) pmax_l = Q_ONE_INT - 1;
    for (int i = 0; i < NUM_ARMS; i++) begin
      target = (i == best) ? pmax_l : longint'(pmin);
      p      = longint'(arm_prob[i]);
      // step truncates toward zero in magnitude
      if (target >= p) begin
        step = (longint'(alpha) * (target - p)) >> 16;
        nxt  = p + step;
      end else begin
        step = (longint'(alpha) * (p - target)) >> 16;
        nxt  = p - step;
      end
      if (nxt < 0) nxt = 0;
      if (nxt > Q_ONE_INT - 1) nxt = Q_ONE_INT - 1;
      arm_prob[i] = Q_W'(nxt);
    end
    acc    = 0;
    chosen = 0;
    for (int i = 0; i < NUM_ARMS; i++) begin
      acc += longint'(arm_prob[i]);
      if (acc > Q_ONE_INT) acc = Q_ONE_INT;
      if (acc > longint'(r.random_draw)) begin
        chosen = i;
        break;
      end
    end
    want.chosen_arm = FIELD_W'(chosen);
    want.best_arm   = FIELD_W'(best);
    pending.push_back(want);
    selects++;
  endfunction

  function void check_result(apsel_pkg::res_t got);
    apsel_pkg::res_t want;
    if (pending.size() == 0) begin
      $error("selection result with none pending: chosen_arm %0d best_arm %0d",
             got.chosen_arm, got.best_arm);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.chosen_arm !== want.chosen_arm) begin
      $error("chosen_arm: expected %0d, actual %0d", want.chosen_arm, got.chosen_arm);
      errors++;
    end
    if (got.best_arm !== want.best_arm) begin
      $error("best_arm: expected %0d, actual %0d", want.best_arm, got.best_arm);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 100;
  localparam int DRAIN_CYCLES   = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int Q_W            = apsel_pkg::Q_W;
  localparam int PMIN_W         = apsel_pkg::PMIN_W;
  localparam int FIELD_W        = apsel_pkg::FIELD_W;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            req_valid = 1'b0;
  logic            req_stall;
  apsel_pkg::req_t req       = '0;
  logic            res_valid;
  logic            res_stall = 1'b0;
  apsel_pkg::res_t res;
  logic            psel      = 1'b0;
  logic            penable   = 1'b0;
  logic            pwrite    = 1'b0;
  logic [2:0]      paddr     = '0;
  logic [31:0]     pwdata    = '0;
  logic [31:0]     prdata;
  logic            pready;

  apsel_scoreboard sb;
  bit no_gaps   = 1'b0;
  bit long_hold = 1'b0;
  int idle_cycles = 0;

  adaptive_pursuit_selector_core u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly back to back, some short gaps, the odd long one
  function automatic int gap_cycles();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request; returns at the edge that takes it, or after a random gap with req_valid low.
  task automatic send_request(input logic c, input logic [FIELD_W-1:0] a,
                              input logic [Q_W-1:0] rw, input logic [Q_W-1:0] d);
    apsel_pkg::req_t r;
    int              gap;
    r.cmd         = c;
    r.arm         = a;
    r.reward      = rw;
    r.random_draw = d;
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    gap = gap_cycles();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    // extra idle margin; a reward write is already stored at the edge that takes it
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == apsel_pkg::REG_MIN_PROB) sb.pmin = val[PMIN_W-1:0];
    else sb.alpha = val[Q_W-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (res_valid && !res_stall) sb.check_result(res);
      if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
          (psel && penable && pready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    int n;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        // hold results long enough for the core to back up into req_stall
        long_hold = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = gap_cycles();
        if (n > 0) begin
          res_stall <= 1'b1;
          repeat (n) @(posedge clk);
          res_stall <= 1'b0;
        end
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    int                 pmin_set [N_PHASES];
    int                 alpha_set [N_PHASES];
    int                 pick;
    logic               c;
    logic [FIELD_W-1:0] a;
    logic [Q_W-1:0]     rw;
    logic [Q_W-1:0]     d;
    logic [Q_W-1:0]     tie_vals [4];
    sb = new();
    // -1 picks a random setting; phase 0 runs on the reset defaults
    pmin_set  = '{655, 0, 8191, 8191, 1, 655, -1, -1};
    alpha_set = '{52429, 65535, 0, 65535, 1, 52429, -1, -1};
    tie_vals  = '{16'h0000, 16'hFFFF, 16'h8000, 16'h1234};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all rewards zero: tie resolves to the last arm
    send_request(apsel_pkg::CMD_SELECT, 3'd0, 16'h0000, 16'h0000);
    send_request(apsel_pkg::CMD_SELECT, 3'd0, 16'h0000, 16'hFFFF);
    send_request(apsel_pkg::CMD_WRITE,  3'd0, 16'hFFFF, 16'h0000);
    send_request(apsel_pkg::CMD_SELECT, 3'd0, 16'h0000, 16'h8000);
    send_request(apsel_pkg::CMD_WRITE,  3'd7, 16'hFFFF, 16'h0000);
    send_request(apsel_pkg::CMD_SELECT, 3'd0, 16'h0000, 16'h0001);
    send_request(apsel_pkg::CMD_WRITE,  3'd1, 16'h0000, 16'hFFFF);
    send_request(apsel_pkg::CMD_WRITE,  3'd2, 16'h0001, 16'h0000);
    send_request(apsel_pkg::CMD_WRITE,  3'd3, 16'h7FFF, 16'h0000);
    send_request(apsel_pkg::CMD_WRITE,  3'd4, 16'h8000, 16'h0000);
    send_request(apsel_pkg::CMD_WRITE,  3'd5, 16'hFFFE, 16'h0000);
    send_request(apsel_pkg::CMD_WRITE,  3'd6, 16'hFFFF, 16'h0000);
    send_request(apsel_pkg::CMD_SELECT, 3'd7, 16'hFFFF, 16'hFFFF);
    send_request(apsel_pkg::CMD_WRITE,  3'd7, 16'h0000, 16'h0000);
    send_request(apsel_pkg::CMD_SELECT, 3'd0, 16'h0000, 16'h2000);
    send_request(apsel_pkg::CMD_SELECT, 3'd0, 16'h0000, 16'hFFFF);
    send_request(apsel_pkg::CMD_SELECT, 3'd0, 16'h0000, 16'h0000);
    send_request(apsel_pkg::CMD_SELECT, 3'd0, 16'h0000, 16'h5555);
    send_request(apsel_pkg::CMD_SELECT, 3'd0, 16'h0000, 16'hAAAA);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        req_valid <= 1'b0;
        wait_drained();
        apb_write(apsel_pkg::REG_MIN_PROB, (pmin_set[ph] < 0) ? $urandom_range(0, 8191)
                                                              : pmin_set[ph]);
        apb_write(apsel_pkg::REG_LEARN_RATE, (alpha_set[ph] < 0) ? $urandom_range(0, 65535)
                                                                 : alpha_set[ph]);
        if (ph == 1) long_hold = 1'b1;
      end
      // top draw exposes roulette fall-through when probabilities sum short of one
      send_request(apsel_pkg::CMD_SELECT, 3'd0, 16'h0000, 16'hFFFF);
      send_request(apsel_pkg::CMD_SELECT, 3'd0, 16'h0000, 16'h0000);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) no_gaps = ($urandom_range(0, 4) == 0);
        c    = 1'($urandom_range(0, 1));
        a    = FIELD_W'($urandom_range(0, 7));
        pick = $urandom_range(0, 7);
        // small value set makes reward ties common
        if (pick < 3) rw = tie_vals[$urandom_range(0, 3)];
        else rw = Q_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 9);
        if (pick == 0) d = 16'h0000;
        else if (pick == 1) d = 16'hFFFF;
        else d = Q_W'($urandom_range(0, 65535));
        send_request(c, a, rw, d);
      end
    end
    req_valid <= 1'b0;
    wait_drained();

    $display("Covered %0d requests with %0d selections checked across %0d register settings,",
             sb.requests, sb.selects, N_PHASES);
    $display("including reward ties, floor saturation and a long result hold-off.");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
